// ----- hdl/lphash_pkg.sv -----
package lphash_pkg;

    localparam int KEY_FIELD_W = 64;
    localparam int LEN_W       = 4;
    localparam int SIZE_W      = 4;

    localparam logic [1:0] CMD_SEARCH = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [1:0] RES_DONE      = 2'd0;
    localparam logic [1:0] RES_NOT_FOUND = 2'd1;
    localparam logic [1:0] RES_PRESENT   = 2'd2;
    localparam logic [1:0] RES_FULL      = 2'd3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    typedef enum logic [1:0] {
        SLOT_EMPTY   = 2'd0,
        SLOT_USED    = 2'd1,
        SLOT_DELETED = 2'd2
    } slot_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HOME,
        ST_PROBE,
        ST_COMPARE,
        ST_INSERT
    } state_t;

    // keeps the first len bytes of a key, clears the rest
    function automatic logic [KEY_FIELD_W-1:0] key_mask(input logic [LEN_W-1:0] len);
        logic [KEY_FIELD_W-1:0] m;
        m = '0;
        for (int b = 0; b < KEY_FIELD_W / 8; b++)
        begin
            if (LEN_W'(b) < len)
            begin
                m[b*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

// ----- hdl/linear_probe_hash_table_unit.sv -----
// Open-addressing hash table of short byte-string keys with linear probing.
// A command is taken when start is high and busy is low; exactly one result
// (status, slot_index) follows, valid for the single cycle in which done is
// high, and the receiver cannot stall it, so it must capture it on that edge.
// The result waits on the one shared compare/subtract sequencer: the home
// slot by repeated subtraction of the table size, the probe walk with its
// registered read of the key memory and, for an insert, the insert walk.
// A malformed command answers in the cycle after its transfer.
// table_size may be written only while busy is low and no result is due.
module linear_probe_hash_table_unit #(
    parameter int TABLE_DEPTH = 8,
    parameter int KEY_BYTES   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [63:0] key_bytes,
    input  logic [3:0]  key_length,
    output logic        done,
    output logic [1:0]  status,
    output logic [2:0]  slot_index,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  table_size
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int RAM_W = KEY_W + lphash_pkg::LEN_W;

    logic [lphash_pkg::SIZE_W-1:0] table_size_reg;
    logic [lphash_pkg::SIZE_W-1:0] size_in_use;
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_addr;
    logic [RAM_W-1:0]              ram_wdata;
    logic [RAM_W-1:0]              ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= lphash_pkg::SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            table_size_reg <= table_size;
        end
    end

    // zero is used as one, anything beyond the depth as the depth
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            size_in_use = lphash_pkg::SIZE_W'(1);
        end
        else if (32'(table_size_reg) > TABLE_DEPTH)
        begin
            size_in_use = lphash_pkg::SIZE_W'(TABLE_DEPTH);
        end
        else
        begin
            size_in_use = table_size_reg;
        end
    end

    lphash_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES),
        .IDX_W       (IDX_W),
        .KEY_W       (KEY_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .command    (command),
        .key_bytes  (key_bytes),
        .key_length (key_length),
        .size       (size_in_use),
        .busy       (busy),
        .done       (done),
        .status     (status),
        .slot_index (slot_index),
        .ram_we     (ram_we),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata)
    );

    lphash_key_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (RAM_W)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

// ----- hdl/lphash_key_ram.sv -----
module lphash_key_ram #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3,
    parameter int DATA_W = 68
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hdl/lphash_ctrl.sv -----
module lphash_ctrl #(
    parameter int TABLE_DEPTH = 8,
    parameter int KEY_BYTES   = 8,
    parameter int IDX_W       = 3,
    parameter int KEY_W       = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [1:0]                        command,
    input  logic [lphash_pkg::KEY_FIELD_W-1:0] key_bytes,
    input  logic [lphash_pkg::LEN_W-1:0]       key_length,
    input  logic [lphash_pkg::SIZE_W-1:0]      size,
    output logic                              busy,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [2:0]                        slot_index,
    output logic                              ram_we,
    output logic [IDX_W-1:0]                  ram_addr,
    output logic [KEY_W+lphash_pkg::LEN_W-1:0] ram_wdata,
    input  logic [KEY_W+lphash_pkg::LEN_W-1:0] ram_rdata
);

    localparam int LW   = lphash_pkg::LEN_W;
    localparam int CMPW = (IDX_W + 1 > LW) ? IDX_W + 1 : LW;
    localparam logic [LW-1:0] MAX_LEN = LW'(KEY_BYTES);

    lphash_pkg::state_t state_reg, state_next;
    lphash_pkg::slot_t  slot_status_reg [TABLE_DEPTH];

    logic [1:0]       cmd_reg, cmd_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [LW-1:0]    len_reg, len_next;
    logic [LW-1:0]    rem_reg, rem_next;
    logic [LW-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0] home_reg, home_next;
    logic [IDX_W-1:0] h_reg, h_next;
    logic             done_reg, done_next;
    logic [1:0]       status_reg, status_next;
    logic [2:0]       slot_reg, slot_next;

    logic               item_ok;
    logic               last_probe;
    logic [IDX_W-1:0]   h_step;
    lphash_pkg::slot_t  cur_slot;
    logic               key_hit;
    logic               set_used;
    logic               set_deleted;
    logic [KEY_W-1:0]   r_key;
    logic [LW-1:0]      r_len;
    logic [lphash_pkg::KEY_FIELD_W-1:0] masked_key;

    assign masked_key = key_bytes & lphash_pkg::key_mask(key_length);
    assign item_ok    = (key_length != '0) && (key_length <= MAX_LEN)
                        && (command != lphash_pkg::CMD_NONE);
    assign last_probe = (cnt_reg + LW'(1)) == size;
    assign h_step     = ((CMPW'(h_reg) + CMPW'(1)) == CMPW'(size)) ? '0 : h_reg + IDX_W'(1);
    assign cur_slot   = slot_status_reg[h_reg];
    assign r_key      = ram_rdata[KEY_W+LW-1:LW];
    assign r_len      = ram_rdata[LW-1:0];
    assign key_hit    = (cur_slot == lphash_pkg::SLOT_USED) && (r_len == len_reg)
                        && (r_key == key_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lphash_pkg::ST_IDLE:
            begin
                if (start && item_ok)
                begin
                    state_next = lphash_pkg::ST_HOME;
                end
            end
            lphash_pkg::ST_HOME:
            begin
                if (rem_reg < size)
                begin
                    state_next = lphash_pkg::ST_PROBE;
                end
            end
            lphash_pkg::ST_PROBE:
            begin
                state_next = lphash_pkg::ST_COMPARE;
            end
            lphash_pkg::ST_COMPARE:
            begin
                if (key_hit)
                begin
                    state_next = lphash_pkg::ST_IDLE;
                end
                else if (cur_slot == lphash_pkg::SLOT_EMPTY || last_probe)
                begin
                    state_next = (cmd_reg == lphash_pkg::CMD_INSERT) ?
                                 lphash_pkg::ST_INSERT : lphash_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = lphash_pkg::ST_PROBE;
                end
            end
            lphash_pkg::ST_INSERT:
            begin
                if (cur_slot != lphash_pkg::SLOT_USED || last_probe)
                begin
                    state_next = lphash_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lphash_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        len_next    = len_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        home_next   = home_reg;
        h_next      = h_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        slot_next   = slot_reg;
        set_used    = 1'b0;
        set_deleted = 1'b0;
        case (state_reg)
            lphash_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = command;
                    key_next = masked_key[KEY_W-1:0];
                    len_next = key_length;
                    rem_next = key_length;
                    if (!item_ok)
                    begin
                        done_next   = 1'b1;
                        status_next = lphash_pkg::RES_NOT_FOUND;
                        slot_next   = '0;
                    end
                end
            end
            lphash_pkg::ST_HOME:
            begin
                // home slot by repeated subtraction of the table size
                if (rem_reg >= size)
                begin
                    rem_next = rem_reg - size;
                end
                else
                begin
                    home_next = IDX_W'(rem_reg);
                    h_next    = IDX_W'(rem_reg);
                    cnt_next  = '0;
                end
            end
            lphash_pkg::ST_COMPARE:
            begin
                if (key_hit)
                begin
                    done_next = 1'b1;
                    slot_next = 3'(h_reg);
                    case (cmd_reg)
                        lphash_pkg::CMD_INSERT:
                        begin
                            status_next = lphash_pkg::RES_PRESENT;
                        end
                        lphash_pkg::CMD_DELETE:
                        begin
                            status_next = lphash_pkg::RES_DONE;
                            set_deleted = 1'b1;
                        end
                        default:
                        begin
                            status_next = lphash_pkg::RES_DONE;
                        end
                    endcase
                end
                else if (cur_slot == lphash_pkg::SLOT_EMPTY || last_probe)
                begin
                    if (cmd_reg == lphash_pkg::CMD_INSERT)
                    begin
                        h_next   = home_reg;
                        cnt_next = '0;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = lphash_pkg::RES_NOT_FOUND;
                        slot_next   = '0;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + LW'(1);
                    h_next   = h_step;
                end
            end
            lphash_pkg::ST_INSERT:
            begin
                // first slot on the path not in use takes the key
                if (cur_slot != lphash_pkg::SLOT_USED)
                begin
                    set_used    = 1'b1;
                    done_next   = 1'b1;
                    status_next = lphash_pkg::RES_DONE;
                    slot_next   = 3'(h_reg);
                end
                else if (last_probe)
                begin
                    done_next   = 1'b1;
                    status_next = lphash_pkg::RES_FULL;
                    slot_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + LW'(1);
                    h_next   = h_step;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lphash_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                slot_status_reg[i] <= lphash_pkg::SLOT_EMPTY;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (set_used)
            begin
                slot_status_reg[h_reg] <= lphash_pkg::SLOT_USED;
            end
            else if (set_deleted)
            begin
                slot_status_reg[h_reg] <= lphash_pkg::SLOT_DELETED;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        len_reg    <= len_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        home_reg   <= home_next;
        h_reg      <= h_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
    end

    assign busy       = (state_reg != lphash_pkg::ST_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign slot_index = slot_reg;
    assign ram_we     = set_used;
    assign ram_addr   = h_reg;
    assign ram_wdata  = {key_reg, len_reg};

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import lphash_pkg::*;

    localparam int DEPTH   = 8;
    localparam int KEY_MAX = 8;
    localparam int POOL_N  = 6;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] key;
        logic [3:0]  len;
    } hash_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] slot;
    } hash_resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  command = CMD_SEARCH;
    logic [63:0] key_bytes = '0;
    logic [3:0]  key_length = '0;
    logic        done;
    logic [1:0]  status;
    logic [2:0]  slot_index;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  table_size = '0;

    // shadow copy of the table contents and the size register
    slot_t       slot_state [DEPTH];
    logic [63:0] slot_key [DEPTH];
    logic [3:0]  slot_len [DEPTH];
    logic [3:0]  model_size;

    hash_req_t   pending_cmds [$];
    hash_resp_t  expected_results [$];
    hash_resp_t  head;
    hash_req_t   next_cmd;
    int          errors = 0;
    int          burst_left = 1;
    int          idle_left = 0;

    logic [63:0] key_pool [POOL_N];
    logic [3:0]  len_pool [POOL_N];

    linear_probe_hash_table_unit #(
        .TABLE_DEPTH (DEPTH),
        .KEY_BYTES   (KEY_MAX)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .key_bytes  (key_bytes),
        .key_length (key_length),
        .done       (done),
        .status     (status),
        .slot_index (slot_index),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .table_size (table_size)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        if (len >= 4'd8)
        begin
            return {64{1'b1}};
        end
        return (64'd1 << (8 * len)) - 64'd1;
    endfunction

    // computes the answer to one command and applies it to the shadow table
    function automatic hash_resp_t hash_table_predict(input hash_req_t req);
        hash_resp_t  r;
        logic [63:0] k;
        int          s;
        int          h;
        int          i;
        int          hit_slot;
        bit          hit;
        r.status = RES_NOT_FOUND;
        r.slot = '0;
        if (req.len >= 1 && req.len <= KEY_MAX && req.command != CMD_NONE)
        begin
            k = req.key & byte_mask(req.len);
            s = (model_size == 0) ? 1 : ((model_size > DEPTH) ? DEPTH : model_size);
            hit = 1'b0;
            hit_slot = 0;
            for (i = 0; i < s; i++)
            begin
                h = (int'(req.len) + i) % s;
                if (slot_state[h] == SLOT_EMPTY)
                begin
                    break;
                end
                if (slot_state[h] == SLOT_USED && slot_len[h] == req.len && slot_key[h] == k)
                begin
                    hit = 1'b1;
                    hit_slot = h;
                    break;
                end
            end
            case (req.command)
                CMD_SEARCH:
                begin
                    if (hit)
                    begin
                        r.status = RES_DONE;
                        r.slot = hit_slot[2:0];
                    end
                end
                CMD_INSERT:
                begin
                    if (hit)
                    begin
                        r.status = RES_PRESENT;
                        r.slot = hit_slot[2:0];
                    end
                    else
                    begin
                        r.status = RES_FULL;
                        for (i = 0; i < s; i++)
                        begin
                            h = (int'(req.len) + i) % s;
                            if (slot_state[h] != SLOT_USED)
                            begin
                                slot_state[h] = SLOT_USED;
                                slot_key[h] = k;
                                slot_len[h] = req.len;
                                r.status = RES_DONE;
                                r.slot = h[2:0];
                                break;
                            end
                        end
                    end
                end
                CMD_DELETE:
                begin
                    if (hit)
                    begin
                        slot_state[hit_slot] = SLOT_DELETED;
                        r.status = RES_DONE;
                        r.slot = hit_slot[2:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
        return r;
    endfunction

    // driver: bursts of commands separated by random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_results.push_back(hash_table_predict({command, key_bytes, key_length}));
            end
            if (!start || !busy)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    next_cmd = pending_cmds.pop_front();
                    command <= next_cmd.command;
                    key_bytes <= next_cmd.key;
                    key_length <= next_cmd.len;
                    start <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every done strobe is a result transfer
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                         $time, status, slot_index);
                errors++;
            end
            else
            begin
                head = expected_results.pop_front();
                if (status !== head.status)
                begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, head.status, status);
                    errors++;
                end
                if (slot_index !== head.slot)
                begin
                    $display("%0t: slot_index mismatch, expected %0d actual %0d",
                             $time, head.slot, slot_index);
                    errors++;
                end
            end
        end
    end

    task automatic queue_cmd(input logic [1:0] cmd, input logic [63:0] key, input logic [3:0] len);
        pending_cmds.push_back({cmd, key, len});
    endtask

    task automatic drain_results();
        @(negedge clk);
        while (pending_cmds.size() != 0 || start || busy || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_table_size(input logic [3:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        table_size <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_size = value;
    endtask

    task automatic random_phase(input int count);
        logic [63:0] key;
        logic [3:0]  len;
        logic [1:0]  cmd;
        int          pick;
        int          n;
        int          j;
        for (j = 0; j < POOL_N; j++)
        begin
            len_pool[j] = 4'($urandom_range(1, KEY_MAX));
            key_pool[j] = {$urandom, $urandom} & byte_mask(len_pool[j]);
        end
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                queue_cmd(CMD_NONE, {$urandom, $urandom}, 4'($urandom_range(0, 15)));
            end
            else if (pick < 10)
            begin
                len = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(KEY_MAX + 1, 15));
                queue_cmd(2'($urandom_range(0, 2)), {$urandom, $urandom}, len);
            end
            else
            begin
                if (pick < 18)
                begin
                    len = 4'($urandom_range(1, KEY_MAX));
                    key = {$urandom, $urandom} & byte_mask(len);
                end
                else
                begin
                    j = $urandom_range(0, POOL_N - 1);
                    len = len_pool[j];
                    key = key_pool[j];
                end
                // junk above the key length must be ignored
                if ($urandom_range(0, 9) < 3)
                begin
                    key = key | ({$urandom, $urandom} & ~byte_mask(len));
                end
                pick = $urandom_range(0, 99);
                cmd = (pick < 40) ? CMD_INSERT : ((pick < 75) ? CMD_SEARCH : CMD_DELETE);
                queue_cmd(cmd, key, len);
            end
        end
    endtask

    initial
    begin
        logic [3:0] sizes [11];
        int         p;
        for (p = 0; p < DEPTH; p++)
        begin
            slot_state[p] = SLOT_EMPTY;
            slot_key[p] = '0;
            slot_len[p] = '0;
        end
        model_size = SIZE_RESET;
        sizes = '{4'd15, 4'd1, 4'd8, 4'd3, 4'd6, 4'd2, 4'd5, 4'd0, 4'd7, 4'd4, 4'd8};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        write_table_size(4'd8);
        queue_cmd(CMD_SEARCH, 64'h61, 4'd1);
        queue_cmd(CMD_INSERT, 64'h61, 4'd1);
        queue_cmd(CMD_INSERT, 64'h62, 4'd1);
        queue_cmd(CMD_INSERT, 64'h61, 4'd1);
        queue_cmd(CMD_SEARCH, 64'hdead_beef_ffff_ff61, 4'd1);
        queue_cmd(CMD_INSERT, {64{1'b1}}, 4'd8);
        // all-zero bytes, collides its way to the first free slot
        queue_cmd(CMD_INSERT, 64'h0, 4'd8);
        queue_cmd(CMD_SEARCH, 64'h0, 4'd8);
        queue_cmd(CMD_DELETE, 64'h61, 4'd1);
        // must walk past the deleted slot
        queue_cmd(CMD_SEARCH, 64'h62, 4'd1);
        queue_cmd(CMD_SEARCH, 64'h61, 4'd1);
        queue_cmd(CMD_DELETE, 64'h61, 4'd1);
        queue_cmd(CMD_INSERT, 64'h63, 4'd1);
        queue_cmd(CMD_SEARCH, {64{1'b1}}, 4'd8);
        queue_cmd(CMD_NONE, 64'h61, 4'd1);
        queue_cmd(CMD_SEARCH, 64'h61, 4'd0);
        queue_cmd(CMD_INSERT, 64'h61, 4'd9);
        queue_cmd(CMD_DELETE, {64{1'b1}}, 4'd15);
        queue_cmd(CMD_INSERT, 64'hffff_ffff, 4'd4);
        drain_results();

        // zero is treated as a single slot
        write_table_size(4'd0);
        queue_cmd(CMD_INSERT, 64'h7a7978, 4'd3);
        queue_cmd(CMD_SEARCH, {64{1'b1}}, 4'd8);
        queue_cmd(CMD_DELETE, {64{1'b1}}, 4'd8);
        queue_cmd(CMD_INSERT, 64'h7a7978, 4'd3);
        queue_cmd(CMD_INSERT, 64'h6f6e6d6c6b, 4'd5);
        drain_results();

        for (p = 0; p < 11; p++)
        begin
            write_table_size(sizes[p]);
            random_phase(120);
            drain_results();
        end

        repeat (40) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
        begin
            $display("linear_probe_hash_table_unit regression: pass");
        end
        else
        begin
            $display("linear_probe_hash_table_unit regression: fail");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("linear_probe_hash_table_unit regression: fail");
        $finish;
    end

endmodule
